FILE: sv/mmn_pkg.sv
// Shared types and constants for the magnetometer min/max normalizer.
`default_nettype none

package mmn_pkg;

   localparam int AXES   = 3;
   localparam int AXIS_W = 2;
   localparam int RAW_W  = 16;
   localparam int EXT_W  = 17;
   localparam int DIFF_W = 18;
   localparam int PROD_W = 31;
   localparam int QUO_W  = 32;

   localparam logic signed [EXT_W-1:0] RESET_MIN     = 17'sd32760;
   localparam logic signed [EXT_W-1:0] RESET_MAX     = -17'sd32760;
   localparam logic signed [EXT_W-1:0] CAL_START_MIN = 17'sd32000;
   localparam logic signed [EXT_W-1:0] CAL_START_MAX = -17'sd32000;
   localparam logic signed [14:0]      NORM_SCALE    = 15'sd10000;
   localparam logic signed [13:0]      NORM_OFFSET   = 14'sd5000;

   typedef enum logic [1:0] {
      REQ_SAMPLE    = 2'd0,
      REQ_CAL_START = 2'd1,
      REQ_CAL_END   = 2'd2,
      REQ_LOAD      = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_DONE
   } back_state_type;

   // one classified request as it sits in the queue
   typedef struct packed {
      req_kind_type                     kind;
      logic [AXES-1:0][RAW_W-1:0]       val;   // sample (remapped) or minima
      logic [AXES-1:0][RAW_W-1:0]       lim;   // maxima for a load
   } cmd_type;

   typedef struct packed {
      logic [AXES-1:0][RAW_W-1:0] norm;
      logic [AXES-1:0][EXT_W-1:0] ext_min;
      logic [AXES-1:0][EXT_W-1:0] ext_max;
      logic                       calibrating;
      logic                       span_zero;
   } rsp_fields_type;

endpackage

`default_nettype wire

FILE: sv/magnetometer_minmax_normalizer_core.sv
// Top level of the magnetometer min/max normalizer core.
//
//  channel  dir  handshake              payload
//  csr      in   csr_valid/csr_ready    csr_data: sensor_variant
//  req      in   req_tvalid/req_tready  req_tdata: six axis words, req_tuser: req_type
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: norms, extremes, flags
//
// A sample beat passes through the back end as pop, execute, then per axis a
// multiply, divider launch, the shared two-bit-per-cycle divider and write-back,
// and finally result load; an axis with zero span skips the divider.
// Other request types go through pop, execute and result load only.
// Reset is synchronous; extremes return to +/-32760, calibration off.
// The command queue keeps taking beats, until it is full, while the back end
// works or the result register waits for rsp_tready.
`default_nettype none

module magnetometer_minmax_normalizer_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic          csr_data,      // sensor_variant
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // raw_x, raw_y, raw_z, load_max_x, load_max_y, load_max_z
   input  wire logic [95:0]   req_tdata,
   input  wire logic [1:0]    req_tuser,     // req_type
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // norm_x, norm_y, norm_z, ext_min_x, ext_max_x, ext_min_y, ext_max_y,
   // ext_min_z, ext_max_z, calibrating, span_zero
   output logic [151:0]       rsp_tdata
);

   mmn_pkg::cmd_type          push_cmd;
   mmn_pkg::cmd_type          pop_cmd;
   mmn_pkg::rsp_fields_type   rsp;
   logic                      push;
   logic                      pop;
   logic                      q_full;
   logic                      q_empty;

   mmn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_raw    (req_tdata[47:0]),
      .req_lim    (req_tdata[95:48]),
      .queue_full (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   mmn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .pop_cmd  (pop_cmd)
   );

   mmn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (pop),
      .q_cmd     (pop_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata[15:0]    = rsp.norm[0];
   assign rsp_tdata[31:16]   = rsp.norm[1];
   assign rsp_tdata[47:32]   = rsp.norm[2];
   assign rsp_tdata[64:48]   = rsp.ext_min[0];
   assign rsp_tdata[81:65]   = rsp.ext_max[0];
   assign rsp_tdata[98:82]   = rsp.ext_min[1];
   assign rsp_tdata[115:99]  = rsp.ext_max[1];
   assign rsp_tdata[132:116] = rsp.ext_min[2];
   assign rsp_tdata[149:133] = rsp.ext_max[2];
   assign rsp_tdata[150]     = rsp.calibrating;
   assign rsp_tdata[151]     = rsp.span_zero;

endmodule

`default_nettype wire

FILE: sv/mmn_front.sv
// Front end: sensor variant register, request intake and axis remap.
`default_nettype none

module mmn_front (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              csr_valid,
   output logic                                                   csr_ready,
   input  wire logic                                              csr_data,
   input  wire logic                                              req_valid,
   output logic                                                   req_ready,
   input  wire logic [1:0]                                        req_kind,
   input  wire logic [mmn_pkg::AXES-1:0][mmn_pkg::RAW_W-1:0]      req_raw,
   input  wire logic [mmn_pkg::AXES-1:0][mmn_pkg::RAW_W-1:0]      req_lim,
   input  wire logic                                              queue_full,
   output logic                                                   push,
   output mmn_pkg::cmd_type                                       push_cmd
);

   localparam int RAW_W = mmn_pkg::RAW_W;
   localparam logic [RAW_W-1:0] MOST_NEG = {1'b1, {(RAW_W-1){1'b0}}};
   localparam logic [RAW_W-1:0] MOST_POS = {1'b0, {(RAW_W-1){1'b1}}};

   logic variant_ff;
   logic variant_in;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      variant_in = variant_ff;
      if (csr_valid) begin
         variant_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= 1'b0;
      end else begin
         variant_ff <= variant_in;
      end
   end

   // alternate part: x' = y, y' = -x with the negation saturating
   always_comb begin
      push_cmd.kind = mmn_pkg::req_kind_type'(req_kind);
      push_cmd.val  = req_raw;
      push_cmd.lim  = req_lim;
      if (variant_ff && push_cmd.kind == mmn_pkg::REQ_SAMPLE) begin
         push_cmd.val[0] = req_raw[1];
         push_cmd.val[1] = (req_raw[0] == MOST_NEG) ? MOST_POS : ('0 - req_raw[0]);
      end
   end

endmodule

`default_nettype wire

FILE: sv/mmn_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module mmn_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  mmn_pkg::cmd_type      push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output mmn_pkg::cmd_type      pop_cmd
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mmn_pkg::cmd_type  slot_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ff, wr_in;
   logic [IDX_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
      if (push) begin
         wr_in = (wr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: sv/mmn_divider.sv
// Signed restoring divider, two quotient bits per cycle, truncates toward zero.
`default_nettype none

module mmn_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [mmn_pkg::PROD_W-1:0]   dividend,
   input  wire logic signed [mmn_pkg::DIFF_W-1:0]   divisor,
   output logic                                     busy,
   output logic                                     done,
   output logic signed [mmn_pkg::QUO_W-1:0]         quotient
);

   localparam int MAG_W  = mmn_pkg::QUO_W;
   localparam int DMAG_W = mmn_pkg::DIFF_W;
   localparam int REM_W  = DMAG_W + 1;
   localparam int ACC_W  = REM_W + MAG_W;
   localparam int ITER   = MAG_W / 2;
   localparam int CNT_W  = $clog2(ITER);

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                 input logic [DMAG_W-1:0] d);
      logic [ACC_W-1:0] sh;
      logic [REM_W-1:0] r;
      logic [MAG_W-1:0] q;
      sh = acc << 1;
      r  = sh[ACC_W-1:MAG_W];
      q  = sh[MAG_W-1:0];
      if (r >= REM_W'(d)) begin
         r    = r - REM_W'(d);
         q[0] = 1'b1;
      end
      return {r, q};
   endfunction

   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [DMAG_W-1:0]        dmag_ff, dmag_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic signed [MAG_W-1:0]  dvd_ext;
   logic signed [REM_W-1:0]  dvs_ext;
   logic [MAG_W-1:0]         dvd_mag;
   logic [REM_W-1:0]         dvs_mag;
   logic [ACC_W-1:0]         acc_one;
   logic [MAG_W-1:0]         quo_mag;

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quo_mag  = acc_ff[MAG_W-1:0];
   assign quotient = neg_ff ? $signed('0 - quo_mag) : $signed(quo_mag);

   always_comb begin
      dvd_ext = MAG_W'(dividend);
      dvs_ext = REM_W'(divisor);
      dvd_mag = dvd_ext[MAG_W-1] ? MAG_W'('0 - dvd_ext) : MAG_W'(dvd_ext);
      dvs_mag = dvs_ext[REM_W-1] ? REM_W'('0 - dvs_ext) : REM_W'(dvs_ext);
      acc_one = div_step(acc_ff, dmag_ff);

      acc_in  = acc_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = {{REM_W{1'b0}}, dvd_mag};
         dmag_in = dvs_mag[DMAG_W-1:0];
         neg_in  = dividend[mmn_pkg::PROD_W-1] ^ divisor[DMAG_W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = div_step(acc_one, dmag_ff);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

endmodule

`default_nettype wire

FILE: sv/mmn_back.sv
// Back end: calibration state, per-axis normalize sequencer, result register.
`default_nettype none

module mmn_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   input  mmn_pkg::cmd_type          q_cmd,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mmn_pkg::rsp_fields_type   rsp
);

   localparam int AXES   = mmn_pkg::AXES;
   localparam int AXIS_W = mmn_pkg::AXIS_W;
   localparam int RAW_W  = mmn_pkg::RAW_W;
   localparam int EXT_W  = mmn_pkg::EXT_W;
   localparam int DIFF_W = mmn_pkg::DIFF_W;
   localparam int PROD_W = mmn_pkg::PROD_W;
   localparam int QUO_W  = mmn_pkg::QUO_W;
   localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

   typedef struct packed {
      logic pop;
      logic exec;
      logic mul;
      logic div_start;
      logic div_wr;
      logic out_load;
   } back_ctl_type;

   function automatic logic [RAW_W-1:0] sat16(input logic signed [QUO_W:0] v);
      logic signed [QUO_W:0] hi;
      logic signed [QUO_W:0] lo;
      hi = (QUO_W+1)'(32767);
      lo = -(QUO_W+1)'(32768);
      if (v > hi) begin
         return hi[RAW_W-1:0];
      end else if (v < lo) begin
         return lo[RAW_W-1:0];
      end
      return v[RAW_W-1:0];
   endfunction

   mmn_pkg::back_state_type         state_ff, state_in;
   back_ctl_type                    ctl;
   mmn_pkg::cmd_type                cmd_ff, cmd_in;
   logic signed [EXT_W-1:0]         min_ff [AXES];
   logic signed [EXT_W-1:0]         min_in [AXES];
   logic signed [EXT_W-1:0]         max_ff [AXES];
   logic signed [EXT_W-1:0]         max_in [AXES];
   logic [RAW_W-1:0]                last_ff [AXES];
   logic [RAW_W-1:0]                last_in [AXES];
   logic                            calib_ff, calib_in;
   logic                            zero_ff, zero_in;
   logic [AXIS_W-1:0]               axis_ff, axis_in;
   logic signed [PROD_W-1:0]        prod_ff, prod_in;
   logic signed [DIFF_W-1:0]        den_ff, den_in;
   logic                            out_valid_ff, out_valid_in;
   mmn_pkg::rsp_fields_type         out_ff, out_in;

   logic signed [RAW_W-1:0]         a_sel;
   logic signed [DIFF_W-1:0]        num_w;
   logic signed [DIFF_W-1:0]        den_w;
   logic signed [PROD_W-1:0]        prod_w;
   logic signed [QUO_W:0]           norm_w;
   logic signed [RAW_W-1:0]         a_ax;

   logic                            div_busy;
   logic                            div_done;
   logic signed [QUO_W-1:0]         div_quo;

   mmn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign q_pop     = ctl.pop;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmn_pkg::ST_IDLE: begin
            if (!q_empty) state_in = mmn_pkg::ST_EXEC;
         end
         mmn_pkg::ST_EXEC: begin
            state_in = (cmd_ff.kind == mmn_pkg::REQ_SAMPLE) ? mmn_pkg::ST_MUL
                                                             : mmn_pkg::ST_DONE;
         end
         mmn_pkg::ST_MUL: begin
            if (den_w != '0) begin
               state_in = mmn_pkg::ST_START;
            end else if (axis_ff == LAST_AXIS) begin
               state_in = mmn_pkg::ST_DONE;
            end
         end
         mmn_pkg::ST_START: begin
            state_in = mmn_pkg::ST_DIV;
         end
         mmn_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = (axis_ff == LAST_AXIS) ? mmn_pkg::ST_DONE : mmn_pkg::ST_MUL;
            end
         end
         mmn_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_ready) state_in = mmn_pkg::ST_IDLE;
         end
         default: begin
            state_in = mmn_pkg::ST_IDLE;
         end
      endcase
   end

   // controls
   always_comb begin
      ctl = '0;
      case (state_ff)
         mmn_pkg::ST_IDLE:  ctl.pop       = !q_empty;
         mmn_pkg::ST_EXEC:  ctl.exec      = 1'b1;
         mmn_pkg::ST_MUL:   ctl.mul       = 1'b1;
         mmn_pkg::ST_START: ctl.div_start = 1'b1;
         mmn_pkg::ST_DIV:   ctl.div_wr    = div_done;
         mmn_pkg::ST_DONE:  ctl.out_load  = !out_valid_ff || rsp_ready;
         default:           ctl           = '0;
      endcase
   end

   // datapath for the current axis
   always_comb begin
      a_sel  = $signed(cmd_ff.val[axis_ff]);
      num_w  = DIFF_W'(a_sel) - DIFF_W'(min_ff[axis_ff]);
      den_w  = DIFF_W'(max_ff[axis_ff]) - DIFF_W'(min_ff[axis_ff]);
      prod_w = num_w * mmn_pkg::NORM_SCALE;
      norm_w = (QUO_W+1)'(div_quo) - (QUO_W+1)'(mmn_pkg::NORM_OFFSET);
   end

   always_comb begin
      cmd_in       = cmd_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      last_in      = last_ff;
      calib_in     = calib_ff;
      zero_in      = zero_ff;
      axis_in      = axis_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      a_ax         = '0;

      if (ctl.pop) cmd_in = q_cmd;

      if (ctl.exec) begin
         zero_in = 1'b0;
         axis_in = '0;
         case (cmd_ff.kind)
            mmn_pkg::REQ_SAMPLE: begin
               // both tests look at the old extremes
               if (calib_ff) begin
                  for (int i = 0; i < AXES; i++) begin
                     a_ax = $signed(cmd_ff.val[i]);
                     if (EXT_W'(a_ax) > max_ff[i]) max_in[i] = EXT_W'(a_ax) + EXT_W'(1);
                     if (EXT_W'(a_ax) < min_ff[i]) min_in[i] = EXT_W'(a_ax) - EXT_W'(1);
                  end
               end
            end
            mmn_pkg::REQ_CAL_START: begin
               if (!calib_ff) begin
                  for (int i = 0; i < AXES; i++) begin
                     min_in[i] = mmn_pkg::CAL_START_MIN;
                     max_in[i] = mmn_pkg::CAL_START_MAX;
                  end
                  calib_in = 1'b1;
               end
            end
            mmn_pkg::REQ_CAL_END: begin
               calib_in = 1'b0;
            end
            mmn_pkg::REQ_LOAD: begin
               for (int i = 0; i < AXES; i++) begin
                  min_in[i] = EXT_W'($signed(cmd_ff.val[i]));
                  max_in[i] = EXT_W'($signed(cmd_ff.lim[i]));
               end
            end
            default: begin
               calib_in = calib_ff;
            end
         endcase
      end

      if (ctl.mul) begin
         prod_in = prod_w;
         den_in  = den_w;
         if (den_w == '0) begin
            last_in[axis_ff] = '0;
            zero_in          = 1'b1;
            axis_in          = axis_ff + 1'b1;
         end
      end

      if (ctl.div_wr) begin
         last_in[axis_ff] = sat16(norm_w);
         axis_in          = axis_ff + 1'b1;
      end

      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (ctl.out_load) begin
         out_valid_in = 1'b1;
         for (int i = 0; i < AXES; i++) begin
            out_in.norm[i]    = last_ff[i];
            out_in.ext_min[i] = min_ff[i];
            out_in.ext_max[i] = max_ff[i];
         end
         out_in.calibrating = calib_ff;
         out_in.span_zero   = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmn_pkg::ST_IDLE;
         calib_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            min_ff[i]  <= mmn_pkg::RESET_MIN;
            max_ff[i]  <= mmn_pkg::RESET_MAX;
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         calib_ff     <= calib_in;
         out_valid_ff <= out_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      zero_ff <= zero_in;
      axis_ff <= axis_in;
      prod_ff <= prod_in;
      den_ff  <= den_in;
      out_ff  <= out_in;
   end

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == mmn_pkg::ST_DIV))
      else $error("divider finished outside the divide state");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmn_pkg::ST_IDLE) |-> !div_busy)
      else $error("divider busy while back end idle");

   a_calib_only_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mmn_pkg::ST_EXEC) |=> $stable(calib_ff))
      else $error("calibration flag moved outside request execution");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the magnetometer min/max normalizer: corners, then random streams.
`timescale 1ns / 1ps

module testbench;

   localparam int     HALF_PERIOD     = 6;
   localparam int     RESET_CYCLES    = 12;
   localparam int     SETTLE_CYCLES   = 4;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     PHASE_ITEMS     = 320;
   localparam int     PRESSURE_ITEMS  = 24;
   localparam int     MAX_REPORTS     = 10;
   localparam longint RUN_LIMIT_NS    = 25_000_000;

   localparam int RSP_W  = 152;
   localparam int FIELDS = 11;
   // result word layout, lowest bit up: norms, min/max pairs per axis, flags
   localparam int FLD_LO [FIELDS] = '{0, 16, 32, 48, 65, 82, 99, 116, 133, 150, 151};
   localparam int FLD_W  [FIELDS] = '{16, 16, 16, 17, 17, 17, 17, 17, 17, 1, 1};

   localparam int SPAN_SCALE   = 10000;
   localparam int CENTER_SHIFT = 5000;
   localparam int BOOT_LO      = 32760;
   localparam int BOOT_HI      = -32760;
   localparam int CAL_LO       = 32000;
   localparam int CAL_HI       = -32000;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;

   magnetometer_minmax_normalizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // predicted block state
   int  axis_lo [3];
   int  axis_hi [3];
   int  last_norm [3];
   bit  cal_on;
   bit  variant_sel;

   logic [RSP_W-1:0] awaited_readings [$];

   int  mismatches;
   int  beats_checked;
   int  sent_total;
   int  variant_writes;
   int  kind_count [4];
   bit  pace_req;
   bit  pace_rsp;
   int  hold_request;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic [15:0] rand_word();
      return 16'($urandom);
   endfunction

   // full-range value with extra weight on the edges
   function automatic logic [15:0] pick_axis();
      case ($urandom_range(0, 15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h8001;
         5: return 16'h7FFE;
         default: return rand_word();
      endcase
   endfunction

   function automatic logic [2:0][15:0] rand_triple();
      logic [2:0][15:0] t;
      for (int i = 0; i < 3; i++) t[i] = rand_word();
      return t;
   endfunction

   function automatic logic [2:0][15:0] pick_triple();
      logic [2:0][15:0] t;
      for (int i = 0; i < 3; i++) t[i] = pick_axis();
      return t;
   endfunction

   function automatic logic [2:0][15:0] xyz(input int x, input int y, input int z);
      logic [2:0][15:0] t;
      t[0] = x[15:0];
      t[1] = y[15:0];
      t[2] = z[15:0];
      return t;
   endfunction

   function automatic logic [16:0] field_bits(input logic [RSP_W-1:0] word, input int k);
      logic [RSP_W-1:0] sh;
      sh = word >> FLD_LO[k];
      return sh[16:0] & 17'((1 << FLD_W[k]) - 1);
   endfunction

   function automatic string field_name(input int k);
      case (k)
         0: return "norm_x";
         1: return "norm_y";
         2: return "norm_z";
         3: return "ext_min_x";
         4: return "ext_max_x";
         5: return "ext_min_y";
         6: return "ext_max_y";
         7: return "ext_min_z";
         8: return "ext_max_z";
         9: return "calibrating";
         default: return "span_zero";
      endcase
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   // update predicted state for one accepted request and queue its result word
   task automatic normalize_request(input mmn_pkg::req_kind_type kind,
                                    input logic [2:0][15:0] val,
                                    input logic [2:0][15:0] lim);
      int               a [3];
      int               m [3];
      int               old_lo;
      int               old_hi;
      int               offs;
      int               span;
      int               t;
      longint           q;
      bit               flat;
      logic [RSP_W-1:0] word;
      flat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         a[i] = int'($signed(val[i]));
         m[i] = int'($signed(lim[i]));
      end
      case (kind)
         mmn_pkg::REQ_SAMPLE: begin
            if (variant_sel) begin
               t = a[0];
               a[0] = a[1];
               a[1] = (t == -32768) ? 32767 : -t;
            end
            for (int i = 0; i < 3; i++) begin
               if (cal_on) begin
                  // both tests look at the old extremes
                  old_lo = axis_lo[i];
                  old_hi = axis_hi[i];
                  if (a[i] > old_hi) axis_hi[i] = a[i] + 1;
                  if (a[i] < old_lo) axis_lo[i] = a[i] - 1;
               end
               offs = a[i] - axis_lo[i];
               span = axis_hi[i] - axis_lo[i];
               if (span == 0) begin
                  flat = 1'b1;
                  last_norm[i] = 0;
               end else begin
                  q = (longint'(offs) * SPAN_SCALE) / longint'(span) - CENTER_SHIFT;
                  if (q > 32767) last_norm[i] = 32767;
                  else if (q < -32768) last_norm[i] = -32768;
                  else last_norm[i] = int'(q);
               end
            end
         end
         mmn_pkg::REQ_CAL_START: begin
            if (!cal_on) begin
               for (int i = 0; i < 3; i++) begin
                  axis_lo[i] = CAL_LO;
                  axis_hi[i] = CAL_HI;
               end
               cal_on = 1'b1;
            end
         end
         mmn_pkg::REQ_CAL_END: cal_on = 1'b0;
         mmn_pkg::REQ_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               axis_lo[i] = a[i];
               axis_hi[i] = m[i];
            end
         end
         default: begin
         end
      endcase
      word = '0;
      for (int i = 0; i < 3; i++) begin
         word[16*i +: 16]      = last_norm[i][15:0];
         word[48 + 34*i +: 17] = axis_lo[i][16:0];
         word[65 + 34*i +: 17] = axis_hi[i][16:0];
      end
      word[150] = cal_on;
      word[151] = flat;
      awaited_readings.push_back(word);
   endtask

   // starts and ends at a falling edge; valid stays up when the next beat follows at once
   task automatic send_beat(input mmn_pkg::req_kind_type kind,
                            input logic [2:0][15:0] val,
                            input logic [2:0][15:0] lim);
      req_tuser  <= kind;
      req_tdata  <= {lim, val};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      normalize_request(kind, val, lim);
      kind_count[kind]++;
      sent_total++;
      @(negedge clock);
      if (pace_req && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_len()) @(negedge clock);
      end
   endtask

   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (awaited_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_variant(input bit v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      variant_sel = v;
      variant_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_load();
      logic [2:0][15:0] lo_w;
      logic [2:0][15:0] hi_w;
      int               r;
      int               p;
      int               q;
      int               t;
      for (int i = 0; i < 3; i++) begin
         r = $urandom_range(0, 19);
         p = int'($signed(pick_axis()));
         q = int'($signed(pick_axis()));
         if (r < 12) begin
            if (p > q) begin t = p; p = q; q = t; end
         end else if (r < 14) begin
            q = p;
         end else if (r < 16) begin
            q = p + $urandom_range(1, 8);
         end else if (r < 18) begin
            if (p < q) begin t = p; p = q; q = t; end
         end
         lo_w[i] = p[15:0];
         hi_w[i] = q[15:0];
      end
      send_beat(mmn_pkg::REQ_LOAD, lo_w, hi_w);
   endtask

   // --------------------------------------------------------------- tests

   task automatic test_reset_extremes();
      // reset extremes are inverted, so the first sample divides by a negative span
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(0, 0, 0), xyz(0, 0, 0));
      send_beat(mmn_pkg::REQ_CAL_END, xyz(-1, -1, -1), xyz(-1, -1, -1));
   endtask

   task automatic test_load_and_saturation();
      send_beat(mmn_pkg::REQ_LOAD, xyz(0, 0, 0), xyz(1, 1, 1));
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(32767, -32768, 0), rand_triple());
      send_beat(mmn_pkg::REQ_LOAD, xyz(-32768, -32768, -32768),
                xyz(32767, 32767, 32767));
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(32767, -32768, 0), rand_triple());
   endtask

   task automatic test_zero_span();
      send_beat(mmn_pkg::REQ_LOAD, xyz(100, -32768, -5), xyz(100, -32768, 5));
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(100, 7, 0), rand_triple());
      // norms repeat, flag drops
      send_beat(mmn_pkg::REQ_CAL_END, rand_triple(), rand_triple());
   endtask

   task automatic test_calibration();
      send_beat(mmn_pkg::REQ_CAL_START, rand_triple(), rand_triple());
      send_beat(mmn_pkg::REQ_CAL_START, rand_triple(), rand_triple());
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(0, 0, 0), rand_triple());
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(32767, -32768, 32767), rand_triple());
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(-32768, 32767, -32768), rand_triple());
      send_beat(mmn_pkg::REQ_CAL_END, rand_triple(), rand_triple());
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(0, 0, 0), rand_triple());
   endtask

   task automatic test_alternate_axes();
      settle_idle();
      write_variant(1'b1);
      // y' = -x with x at the negative limit saturates
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(-32768, -32768, -32768), rand_triple());
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(32767, 1, 0), rand_triple());
      send_beat(mmn_pkg::REQ_CAL_START, rand_triple(), rand_triple());
      send_beat(mmn_pkg::REQ_SAMPLE, xyz(-32768, 5, 12345), rand_triple());
      send_beat(mmn_pkg::REQ_CAL_END, rand_triple(), rand_triple());
   endtask

   task automatic test_random_traffic(input bit variant, input bit paced, input int items);
      int first;
      int r;
      int n;
      settle_idle();
      write_variant(variant);
      pace_req = paced;
      pace_rsp = paced;
      first = sent_total;
      while (sent_total - first < items) begin
         r = $urandom_range(0, 19);
         if (r < 8) begin
            send_beat(mmn_pkg::REQ_CAL_START, rand_triple(), rand_triple());
            n = $urandom_range(2, 24);
            for (int k = 0; k < n; k++)
               send_beat(mmn_pkg::REQ_SAMPLE, pick_triple(), rand_triple());
            if ($urandom_range(0, 5) != 0)
               send_beat(mmn_pkg::REQ_CAL_END, rand_triple(), rand_triple());
         end else if (r < 11) begin
            send_random_load();
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
               send_beat(mmn_pkg::REQ_SAMPLE, pick_triple(), rand_triple());
         end else if (r < 16) begin
            send_beat(mmn_pkg::REQ_SAMPLE, pick_triple(), rand_triple());
         end else begin
            send_beat(mmn_pkg::req_kind_type'(2'($urandom_range(0, 3))),
                      rand_triple(), rand_triple());
         end
      end
   endtask

   task automatic test_output_backpressure();
      settle_idle();
      pace_req = 1'b0;
      pace_rsp = 1'b1;
      hold_request = HOLD_OFF_CYCLES;
      while (hold_request != 0) @(negedge clock);
      for (int k = 0; k < PRESSURE_ITEMS; k++)
         send_beat(mmn_pkg::req_kind_type'(2'(k % 4)), pick_triple(), rand_triple());
   endtask

   // --------------------------------------------------------------- receiver

   initial begin : rsp_ready_driver
      int hold;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end else if (!pace_rsp) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : result_check
      logic [RSP_W-1:0] want;
      logic [16:0]      want_f;
      logic [16:0]      got_f;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (awaited_readings.size() == 0) begin
            note_mismatch($sformatf("result beat %0d with nothing expected: %h",
                                    beats_checked, rsp_tdata));
         end else begin
            want = awaited_readings.pop_front();
            for (int k = 0; k < FIELDS; k++) begin
               want_f = field_bits(want, k);
               got_f  = field_bits(rsp_tdata, k);
               if (want_f !== got_f)
                  note_mismatch($sformatf("beat %0d %s: expected %h, got %h",
                                          beats_checked, field_name(k), want_f, got_f));
            end
         end
      end
   end

   // --------------------------------------------------------------- sequence

   initial begin : run_tests
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = mmn_pkg::REQ_SAMPLE;
      pace_req   = 1'b1;
      pace_rsp   = 1'b1;
      hold_request = 0;
      for (int i = 0; i < 3; i++) begin
         axis_lo[i]   = BOOT_LO;
         axis_hi[i]   = BOOT_HI;
         last_norm[i] = 0;
      end
      cal_on      = 1'b0;
      variant_sel = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_extremes();
      test_load_and_saturation();
      test_zero_span();
      test_calibration();
      test_alternate_axes();

      test_random_traffic(1'b0, 1'b1, PHASE_ITEMS);
      test_random_traffic(1'b1, 1'b1, PHASE_ITEMS);
      test_random_traffic(1'b0, 1'b0, PHASE_ITEMS);
      test_output_backpressure();
      test_random_traffic(1'b1, 1'b0, PHASE_ITEMS);
      test_random_traffic(1'b1, 1'b1, PHASE_ITEMS);
      settle_idle();

      $display("Checked %0d result beats for %0d requests: %0d samples, %0d starts,",
               beats_checked, sent_total, kind_count[mmn_pkg::REQ_SAMPLE],
               kind_count[mmn_pkg::REQ_CAL_START]);
      $display("%0d ends, %0d loads; both axis orders over %0d variant writes;",
               kind_count[mmn_pkg::REQ_CAL_END], kind_count[mmn_pkg::REQ_LOAD],
               variant_writes);
      $display("paced, unpaced and %0d-cycle held-off output.", HOLD_OFF_CYCLES);
      if (mismatches == 0 && awaited_readings.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d results outstanding", awaited_readings.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
sv/mmn_pkg.sv
sv/mmn_front.sv
sv/mmn_queue.sv
sv/mmn_divider.sv
sv/mmn_back.sv
sv/magnetometer_minmax_normalizer_core.sv
bench/testbench.sv
